// File: src/vmetoc_pkg.sv
// Shared constants, types and state encoding for the VM exit time offset compensator.
`default_nettype none
package vmetoc_pkg;

    localparam int WORD_W     = 64;
    localparam int TIME_BITS  = 64;
    localparam int NUM_W      = 8;
    localparam int DEN_W      = 8;
    localparam int EAT_W      = 20;
    localparam int MINADV_W   = 16;
    localparam int OVH_W      = 16;
    localparam int RING_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // excess is below 2^(TIME_BITS-1), so the scaled product needs this many bits
    localparam int PROD_W    = TIME_BITS - 1 + NUM_W;
    localparam int QUOT_W    = EAT_W + 1;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    localparam int IN_FIELDS_W  = 5 * WORD_W + 3 + RING_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 5 * WORD_W + EAT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [RING_W-1:0] RING_KERNEL = 2'd0;
    localparam logic [RING_W-1:0] RING_USER   = 2'd3;

    localparam logic [MINADV_W-1:0] MIN_ADV_RST = 16'd200;
    localparam logic [EAT_W-1:0]    MAX_EAT_RST = 20'd50000;
    localparam logic [NUM_W-1:0]    NUM_RST     = 8'd1;
    localparam logic [DEN_W-1:0]    DEN_RST     = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMP_ENABLE     = 3'd0,
        CFG_MIN_ADVANCE     = 3'd1,
        CFG_SCALE_NUM       = 3'd2,
        CFG_SCALE_DEN       = 3'd3,
        CFG_MAX_EAT         = 3'd4,
        CFG_ZERO_ON_NOHIDE  = 3'd5,
        CFG_PERF_OVERHEAD   = 3'd6,
        CFG_REFCLK_OVERHEAD = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELAPSED,
        S_EXCESS,
        S_MUL,
        S_DIV,
        S_CLAMP,
        S_OFF,
        S_GUEST,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage
`default_nettype wire

// File: src/vmetoc_div.sv
// Bit-serial restoring divider: scaled excess over the configured denominator.
`default_nettype none
module vmetoc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [vmetoc_pkg::PROD_W-1:0] i_dividend,
    input  wire logic [vmetoc_pkg::DEN_W-1:0]  i_den,
    output vmetoc_pkg::t_div_res               o_res
);
    import vmetoc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_shift;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [QUOT_W-1:0]    r_quot;
    logic                 r_ovf;

    logic [DEN_W:0] n_trial;
    logic           n_ge;

    assign n_trial = {r_rem, r_shift[PROD_W-1]};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_den   <= i_den;
            r_rem   <= '0;
            r_quot  <= '0;
            r_ovf   <= 1'b0;
        end else if (r_busy) begin
            r_shift <= {r_shift[PROD_W-2:0], 1'b0};
            r_rem   <= n_ge ? DEN_W'(n_trial - {1'b0, r_den}) : n_trial[DEN_W-1:0];
            r_quot  <= {r_quot[QUOT_W-2:0], n_ge};
            // bits above the clamp range only matter as "too big"
            r_ovf   <= r_ovf | r_quot[QUOT_W-1];
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;

endmodule
`default_nettype wire

// File: src/vm_exit_time_offset_compensator_unit.sv
// Top level of the VM exit time offset compensator.
// One input word is one VM exit; one output word comes back for each. A hidden exit passes
// the elapsed, excess and multiply steps, then a bit-serial divide of the scaled excess by
// scale_den giving one quotient bit per clock, a step that sees the divider finish, then
// clamp, offset, guest time, floor compare and the output load. An exit that is not hidden,
// or any exit with compensation disabled, goes straight from acceptance to the output load.
// The output load waits while the output register holds an untaken word; the next exit is
// taken the cycle after the load. One exit is worked on at a time; a finished word waits in
// the output register, so the next exit may be accepted before it is taken. Registers are
// written through the plain write port and must only be changed while the block is idle.
`default_nettype none
module vm_exit_time_offset_compensator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [vmetoc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [vmetoc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // entry_time, now_time, aperf_saved, mperf_saved, fixed2_global_on, guest_ring,
    // fixed2_kernel_on, fixed2_user_on, fixed2_value, zero pad
    input  wire logic [vmetoc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // hide_exit
    input  wire logic [0:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // time_offset, guest_time, aperf_reload, mperf_reload, fixed2_new, hidden_cycles, zero pad
    output logic [vmetoc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // fixed2_write
    output logic [0:0]                             m_axis_tuser
);
    import vmetoc_pkg::*;

    // configuration
    logic                r_comp_en;
    logic [MINADV_W-1:0] r_min_adv;
    logic [NUM_W-1:0]    r_num;
    logic [DEN_W-1:0]    r_den;
    logic [EAT_W-1:0]    r_max_eat;
    logic                r_zero_nohide;
    logic [OVH_W-1:0]    r_perf_ovh;
    logic [OVH_W-1:0]    r_ref_ovh;

    // persistent state
    logic [TIME_BITS-1:0] r_offset;
    logic [TIME_BITS-1:0] r_last;

    // per-exit working registers
    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_now, r_entry, r_elapsed;
    logic [TIME_BITS-2:0] r_excess;
    logic [EAT_W-1:0]     r_eat;
    logic [TIME_BITS-1:0] r_new_off, r_min_allowed, r_guest;
    logic [WORD_W-1:0]    r_aperf_rl, r_mperf_rl, r_f2_new;
    logic                 r_f2_wr;

    // output register
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_o_off, r_o_guest, r_o_aperf, r_o_mperf, r_o_f2_new;
    logic                 r_o_f2_wr;
    logic [EAT_W-1:0]     r_o_eat;

    // input fields
    logic                 in_hide;
    logic [WORD_W-1:0]    in_entry, in_now, in_aperf, in_mperf, in_f2;
    logic                 in_g_on, in_k_on, in_u_on;
    logic [RING_W-1:0]    in_ring;

    logic                 s_acc, m_acc, load_out, div_start, f2_hit, sat, guest_low;
    logic [TIME_BITS-1:0] nohide_off;
    logic [TIME_BITS:0]   adv_diff;
    logic [PROD_W-1:0]    prod;
    t_div_res             div_res;

    assign in_hide  = s_axis_tuser[0];
    assign in_entry = s_axis_tdata[WORD_W-1:0];
    assign in_now   = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign in_aperf = s_axis_tdata[3*WORD_W-1:2*WORD_W];
    assign in_mperf = s_axis_tdata[4*WORD_W-1:3*WORD_W];
    assign in_g_on  = s_axis_tdata[4*WORD_W];
    assign in_ring  = s_axis_tdata[4*WORD_W+RING_W:4*WORD_W+1];
    assign in_k_on  = s_axis_tdata[4*WORD_W+RING_W+1];
    assign in_u_on  = s_axis_tdata[4*WORD_W+RING_W+2];
    assign in_f2    = s_axis_tdata[5*WORD_W+RING_W+2:4*WORD_W+RING_W+3];

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    assign f2_hit = in_g_on && (((in_ring == RING_KERNEL) && in_k_on)
                             || ((in_ring == RING_USER) && in_u_on));
    assign nohide_off = r_zero_nohide ? '0 : r_offset;

    // elapsed must be non-negative and beyond the minimum advance
    assign adv_diff = {1'b0, r_elapsed} - (TIME_BITS+1)'(r_min_adv);

    assign prod      = PROD_W'(r_excess) * PROD_W'(r_num);
    assign div_start = (r_state == S_MUL);
    assign sat       = div_res.ovf || (div_res.quot > {1'b0, r_max_eat});
    assign guest_low = $signed(r_guest) < $signed(r_min_allowed);

    vmetoc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_den      (r_den),
        .o_res      (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_en     <= 1'b1;
            r_min_adv     <= MIN_ADV_RST;
            r_num         <= NUM_RST;
            r_den         <= DEN_RST;
            r_max_eat     <= MAX_EAT_RST;
            r_zero_nohide <= 1'b1;
            r_perf_ovh    <= '0;
            r_ref_ovh     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COMP_ENABLE:     r_comp_en     <= i_cfg_wdata[0];
                CFG_MIN_ADVANCE:     r_min_adv     <= i_cfg_wdata[MINADV_W-1:0];
                CFG_SCALE_NUM:       r_num         <= i_cfg_wdata[NUM_W-1:0];
                CFG_SCALE_DEN:       r_den         <= i_cfg_wdata[DEN_W-1:0];
                CFG_MAX_EAT:         r_max_eat     <= i_cfg_wdata[EAT_W-1:0];
                CFG_ZERO_ON_NOHIDE:  r_zero_nohide <= i_cfg_wdata[0];
                CFG_PERF_OVERHEAD:   r_perf_ovh    <= i_cfg_wdata[OVH_W-1:0];
                CFG_REFCLK_OVERHEAD: r_ref_ovh     <= i_cfg_wdata[OVH_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = (r_comp_en && in_hide) ? S_ELAPSED : S_DONE;
                end
            end
            S_ELAPSED: n_state = S_EXCESS;
            S_EXCESS:  n_state = S_MUL;
            S_MUL:     n_state = S_DIV;
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP:   n_state = S_OFF;
            S_OFF:     n_state = S_GUEST;
            S_GUEST:   n_state = S_CMP;
            S_CMP:     n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_now   <= in_now[TIME_BITS-1:0];
            r_entry <= in_entry[TIME_BITS-1:0];
            r_eat   <= '0;
            if (!r_comp_en) begin
                r_aperf_rl <= '0;
                r_mperf_rl <= '0;
                r_f2_wr    <= 1'b0;
                r_f2_new   <= '0;
                r_new_off  <= '0;
                r_guest    <= in_now[TIME_BITS-1:0];
            end else begin
                r_aperf_rl <= in_aperf - WORD_W'(r_perf_ovh);
                r_mperf_rl <= in_mperf - WORD_W'(r_perf_ovh);
                r_f2_wr    <= f2_hit;
                r_f2_new   <= f2_hit ? (in_f2 - WORD_W'(r_ref_ovh)) : '0;
                r_new_off  <= nohide_off;
                r_guest    <= in_now[TIME_BITS-1:0] + nohide_off;
            end
        end
        case (r_state)
            S_ELAPSED: r_elapsed <= r_now - r_entry;
            S_EXCESS: begin
                if (!r_elapsed[TIME_BITS-1] && !adv_diff[TIME_BITS] && (adv_diff != '0)) begin
                    r_excess <= adv_diff[TIME_BITS-2:0];
                end else begin
                    r_excess <= '0;
                end
            end
            S_CLAMP: r_eat <= sat ? r_max_eat : div_res.quot[EAT_W-1:0];
            S_OFF: begin
                r_new_off     <= r_offset - TIME_BITS'(r_eat);
                r_min_allowed <= r_last + TIME_BITS'(r_min_adv);
            end
            S_GUEST: r_guest <= r_now + r_new_off;
            S_CMP: begin
                if (guest_low) begin
                    r_guest   <= r_min_allowed;
                    r_new_off <= r_min_allowed - r_now;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_last   <= '0;
        end else if (load_out) begin
            r_offset <= r_new_off;
            r_last   <= r_guest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_off    <= WORD_W'($signed(r_new_off));
            r_o_guest  <= WORD_W'(r_guest);
            r_o_aperf  <= r_aperf_rl;
            r_o_mperf  <= r_mperf_rl;
            r_o_f2_wr  <= r_f2_wr;
            r_o_f2_new <= r_f2_new;
            r_o_eat    <= r_eat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_o_f2_wr;
    assign m_axis_tdata  = {(OUT_DATA_W-OUT_FIELDS_W)'(0), r_o_eat, r_o_f2_new, r_o_mperf,
                            r_o_aperf, r_o_guest, r_o_off};

    // the divider finishes exactly when the sequencer is waiting on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider done outside divide phase");

    a_div_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && div_res.done |=> (r_state == S_CLAMP))
        else $error("sequencer missed divider done");

    // guest time never ends below the minimum allowed time on a hidden exit
    a_guest_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> !($signed(r_guest) < $signed(r_min_allowed)))
        else $error("guest time below minimum advance");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("new exit accepted while busy");

endmodule
`default_nettype wire

// File: dv/vm_exit_time_offset_compensator_unit_tb.sv
// Self-checking testbench for the VM exit time offset compensator: stream driver, monitor and predictor.
`timescale 1ns / 1ps
module vm_exit_time_offset_compensator_unit_tb;
    import vmetoc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic        hide;
        logic [63:0] entry;
        logic [63:0] now;
        logic [63:0] aperf;
        logic [63:0] mperf;
        logic        g_on;
        logic [1:0]  ring;
        logic        k_on;
        logic        u_on;
        logic [63:0] f2;
    } t_exit;

    typedef struct packed {
        logic [63:0] tsc_off;
        logic [63:0] guest;
        logic [63:0] aperf;
        logic [63:0] mperf;
        logic        f2_write;
        logic [63:0] f2_new;
        logic [19:0] hidden;
    } t_resume;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    vm_exit_time_offset_compensator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // register mirror and compensation state
    logic        comp_on     = 1'b1;
    logic [15:0] min_adv     = MIN_ADV_RST;
    logic [7:0]  num         = NUM_RST;
    logic [7:0]  den         = DEN_RST;
    logic [19:0] eat_max     = MAX_EAT_RST;
    logic        zero_nohide = 1'b1;
    logic [15:0] perf_ovh    = '0;
    logic [15:0] refclk_ovh  = '0;
    logic [63:0] pred_offset = '0;
    logic [63:0] last_guest  = '0;

    t_exit   exit_q[$];
    t_resume resume_q[$];
    t_exit   bus_exit;
    logic [63:0] host_tsc;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int errors       = 0;
    int words_seen   = 0;
    int stall_cycles = 0;

    function automatic t_resume compensate_exit(input t_exit x);
        t_resume     r;
        logic [63:0] elapsed, excess, quo, rem, eat, new_off, guest, floor_t;
        r   = '0;
        eat = '0;
        if (!comp_on) begin
            pred_offset = '0;
            last_guest  = x.now;
            r.guest     = x.now;
            return r;
        end
        if (x.g_on && ((x.ring == RING_KERNEL && x.k_on) || (x.ring == RING_USER && x.u_on))) begin
            r.f2_write = 1'b1;
            r.f2_new   = x.f2 - refclk_ovh;
        end
        if (!x.hide) begin
            if (zero_nohide)
                pred_offset = '0;
            last_guest = x.now + pred_offset;
        end else begin
            elapsed = x.now - x.entry;
            excess  = (!elapsed[63] && elapsed > min_adv) ? elapsed - min_adv : 64'd0;
            // exact floor(excess * num / den), clamped; zero divisor saturates
            if (den == 0) begin
                eat = eat_max;
            end else begin
                quo = excess / den;
                rem = excess % den;
                if (num != 0 && quo > 64'd1048576) begin
                    eat = eat_max;
                end else begin
                    eat = quo * num + (rem * num) / den;
                    if (eat > eat_max)
                        eat = eat_max;
                end
            end
            new_off = pred_offset - eat;
            guest   = x.now + new_off;
            floor_t = last_guest + min_adv;
            if ($signed(guest) < $signed(floor_t)) begin
                guest   = floor_t;
                new_off = guest - x.now;
            end
            pred_offset = new_off;
            last_guest  = guest;
        end
        r.tsc_off = pred_offset;
        r.guest   = last_guest;
        r.aperf   = x.aperf - perf_ovh;
        r.mperf   = x.mperf - perf_ovh;
        r.hidden  = eat[19:0];
        return r;
    endfunction

    function automatic t_exit mk_exit(input logic h, input logic [63:0] t_in, t_out,
                                      input logic [1:0] rg, input logic [2:0] en,
                                      input logic [63:0] fill);
        t_exit x;
        x.hide  = h;
        x.entry = t_in;
        x.now   = t_out;
        x.ring  = rg;
        {x.g_on, x.k_on, x.u_on} = en;
        x.aperf = fill;
        x.mperf = ~fill;
        x.f2    = fill;
        return x;
    endfunction

    function automatic logic [63:0] rand_count();
        if ($urandom_range(4) == 0)
            return 64'($urandom_range(70000));
        return {$urandom, $urandom};
    endfunction

    // well-formed exits on a moving host clock, with occasional jumps and odd spans
    function automatic t_exit random_exit();
        t_exit       x;
        logic [63:0] span;
        case ($urandom_range(19))
            0:       host_tsc = {$urandom, $urandom};
            1:       host_tsc = host_tsc - 64'($urandom_range(100000));
            default: host_tsc = host_tsc + 64'($urandom_range(20000));
        endcase
        case ($urandom_range(9))
            0, 1:    span = 64'($urandom_range(400));
            2, 3, 4: span = 64'($urandom_range(4000));
            5, 6:    span = 64'($urandom_range(400000));
            7:       span = {$urandom, $urandom} >> $urandom_range(63);
            8:       span = 64'd0 - 64'($urandom_range(5000));
            default: span = {$urandom, $urandom};
        endcase
        x.hide   = ($urandom_range(9) < 7);
        x.entry  = host_tsc;
        x.now    = host_tsc + span;
        host_tsc = x.now;
        x.aperf  = rand_count();
        x.mperf  = rand_count();
        x.f2     = rand_count();
        x.g_on   = ($urandom_range(3) != 0);
        x.ring   = 2'($urandom_range(3));
        x.k_on   = 1'($urandom_range(1));
        x.u_on   = 1'($urandom_range(1));
        return x;
    endfunction

    task automatic report_mismatch(input string fld, input logic [63:0] got, want);
        $display("word %0d: %s got %h expected %h", words_seen, fld, got, want);
        errors++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_COMP_ENABLE:     comp_on     = val[0];
            CFG_MIN_ADVANCE:     min_adv     = val[15:0];
            CFG_SCALE_NUM:       num         = val[7:0];
            CFG_SCALE_DEN:       den         = val[7:0];
            CFG_MAX_EAT:         eat_max     = val[19:0];
            CFG_ZERO_ON_NOHIDE:  zero_nohide = val[0];
            CFG_PERF_OVERHEAD:   perf_ovh    = val[15:0];
            CFG_REFCLK_OVERHEAD: refclk_ovh  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic c, input logic [15:0] ma, input logic [7:0] n, d,
                            input logic [19:0] me, input logic z, input logic [15:0] po, ro);
        write_reg(CFG_COMP_ENABLE, 20'(c));
        write_reg(CFG_MIN_ADVANCE, 20'(ma));
        write_reg(CFG_SCALE_NUM, 20'(n));
        write_reg(CFG_SCALE_DEN, 20'(d));
        write_reg(CFG_MAX_EAT, me);
        write_reg(CFG_ZERO_ON_NOHIDE, 20'(z));
        write_reg(CFG_PERF_OVERHEAD, 20'(po));
        write_reg(CFG_REFCLK_OVERHEAD, 20'(ro));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        while (exit_q.size() != 0 || s_axis_tvalid || resume_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // driver: presents queued exits, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                resume_q.push_back(compensate_exit(bus_exit));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (exit_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    bus_exit = exit_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= bus_exit.hide;
                    s_axis_tdata  <= IN_DATA_W'({bus_exit.f2, bus_exit.u_on, bus_exit.k_on,
                                                 bus_exit.ring, bus_exit.g_on, bus_exit.mperf,
                                                 bus_exit.aperf, bus_exit.now, bus_exit.entry});
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_resume got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.tsc_off  = m_axis_tdata[63:0];
                got.guest    = m_axis_tdata[127:64];
                got.aperf    = m_axis_tdata[191:128];
                got.mperf    = m_axis_tdata[255:192];
                got.f2_new   = m_axis_tdata[319:256];
                got.hidden   = m_axis_tdata[339:320];
                got.f2_write = m_axis_tuser[0];
                if (resume_q.size() == 0) begin
                    $display("word %0d: result with nothing expected", words_seen);
                    errors++;
                end else begin
                    want = resume_q.pop_front();
                    if (got.tsc_off != want.tsc_off)
                        report_mismatch("time_offset", got.tsc_off, want.tsc_off);
                    if (got.guest != want.guest)
                        report_mismatch("guest_time", got.guest, want.guest);
                    if (got.aperf != want.aperf)
                        report_mismatch("aperf_reload", got.aperf, want.aperf);
                    if (got.mperf != want.mperf)
                        report_mismatch("mperf_reload", got.mperf, want.mperf);
                    if (got.f2_write != want.f2_write)
                        report_mismatch("fixed2_write", 64'(got.f2_write), 64'(want.f2_write));
                    if (got.f2_new != want.f2_new)
                        report_mismatch("fixed2_new", got.f2_new, want.f2_new);
                    if (got.hidden != want.hidden)
                        report_mismatch("hidden_cycles", 64'(got.hidden), 64'(want.hidden));
                end
                words_seen++;
            end
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        host_tsc = {$urandom, $urandom};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, directed exits first
        src_idle_pct = 26;
        snk_idle_pct = 82;
        exit_q.push_back(mk_exit(0, '0, '0, RING_KERNEL, 3'b000, '0));
        exit_q.push_back(mk_exit(1, '1, '1, RING_USER, 3'b111, '1));
        exit_q.push_back(mk_exit(1, 64'd1000, 64'd1200, RING_KERNEL, 3'b110, 64'd5));
        exit_q.push_back(mk_exit(1, 64'd2000, 64'd2201, RING_KERNEL, 3'b100, 64'd7));
        exit_q.push_back(mk_exit(1, 64'd3000, 64'd103000, RING_USER, 3'b101, 64'h1234));
        exit_q.push_back(mk_exit(1, 64'd5000, 64'd5000 + (64'd1 << 40), RING_USER, 3'b100, 64'd9));
        exit_q.push_back(mk_exit(0, '0, (64'd1 << 40) + 64'd10000, 2'd1, 3'b111, 64'd3));
        exit_q.push_back(mk_exit(1, (64'd1 << 40) + 64'd20000, (64'd1 << 40) + 64'd15000,
                                 2'd2, 3'b111, 64'd11));
        exit_q.push_back(mk_exit(1, '0, 64'd1 << 63, RING_KERNEL, 3'b011, 64'd13));
        exit_q.push_back(mk_exit(1, 64'd100, 64'd50, RING_USER, 3'b110, 64'd17));
        exit_q.push_back(mk_exit(1, 64'd10, 64'd1510, RING_KERNEL, 3'b110, 64'hAAAA));
        exit_q.push_back(mk_exit(0, '0, '1 - 64'd50, RING_USER, 3'b101, 64'h5555));
        // minimum allowed time wraps past zero
        exit_q.push_back(mk_exit(1, '1 - 64'd50, '1 - 64'd10, RING_USER, 3'b101, 64'd1));
        exit_q.push_back(mk_exit(1, '0, 64'h7FFF_FFFF_FFFF_FFFF, RING_KERNEL, 3'b110, 64'd2));
        exit_q.push_back(mk_exit(1, 64'd7, 64'd7 + 64'd333, 2'd1, 3'b111, '1));
        exit_q.push_back(mk_exit(1, 64'd7, 64'd40000, 2'd2, 3'b111, '0));
        repeat (60) exit_q.push_back(random_exit());
        wait_drain();

        // widest scaling, no zeroing, largest overheads; long output stall
        set_regs(1'b1, 16'd0, 8'd255, 8'd1, 20'hFFFFF, 1'b0, 16'hFFFF, 16'hFFFF);
        host_tsc = {$urandom, $urandom};
        repeat (75) exit_q.push_back(random_exit());
        hold_reqs++;
        wait_drain();

        src_idle_pct = 82;
        snk_idle_pct = 26;
        set_regs(1'b1, 16'hFFFF, 8'd0, 8'd255, 20'd0, 1'b1, 16'd1, 16'd1);
        repeat (37) exit_q.push_back(random_exit());
        wait_drain();
        repeat (38) exit_q.push_back(random_exit());
        wait_drain();

        // compensation off
        set_regs(1'b0, 16'($urandom), 8'($urandom), 8'($urandom_range(1, 255)),
                 20'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        repeat (75) exit_q.push_back(random_exit());
        wait_drain();

        // zero divisor saturates the hidden amount
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_regs(1'b1, 16'($urandom_range(1000)), 8'($urandom), 8'd0,
                 20'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        host_tsc = {$urandom, $urandom};
        repeat (75) exit_q.push_back(random_exit());
        wait_drain();

        set_regs(1'b1, 16'($urandom_range(2000)), 8'($urandom), 8'($urandom_range(1, 255)),
                 20'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        repeat (75) exit_q.push_back(random_exit());
        wait_drain();

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
